// ----- design/cau_pkg.sv -----
package cau_pkg;

    // Width of the operand and result ports
    localparam int OUT_W  = 32;
    localparam int KIND_W = 2;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    // Control carried alongside the data through the divider stages
    typedef struct packed {
        logic valid;
        logic is_div;   // lanes hold a live division
        logic dbz;      // divide with zero divisor
        logic ovf;      // saturation seen on a non-divide result
        logic sat_re;   // real quotient is known to exceed the range
        logic sat_im;
        logic neg_re;   // real quotient gets a negative sign
        logic neg_im;
    } t_ctl;

endpackage

// ----- design/cau_div_step.sv -----
// One restoring-division step for the real and imaginary lanes.
// Each lane shifts one dividend bit out of x into the partial remainder
// and shifts the quotient bit back into x.
module cau_div_step import cau_pkg::*; #(
    parameter int W = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  t_ctl            i_ctl,
    input  logic [2*W-1:0]  i_den,
    input  logic [2*W-1:0]  i_rem_re,
    input  logic [2*W-1:0]  i_rem_im,
    input  logic [W-1:0]    i_x_re,
    input  logic [W-1:0]    i_x_im,
    output t_ctl            o_ctl,
    output logic [2*W-1:0]  o_den,
    output logic [2*W-1:0]  o_rem_re,
    output logic [2*W-1:0]  o_rem_im,
    output logic [W-1:0]    o_x_re,
    output logic [W-1:0]    o_x_im
);

    logic [2*W:0]   trial_re, trial_im;
    logic [2*W:0]   diff_re, diff_im;
    logic           ge_re, ge_im;
    logic [2*W-1:0] n_rem_re, n_rem_im;
    logic [W-1:0]   n_x_re, n_x_im;

    // Compare and subtract
    always_comb begin
        trial_re = {i_rem_re, i_x_re[W-1]};
        trial_im = {i_rem_im, i_x_im[W-1]};
        diff_re  = trial_re - {1'b0, i_den};
        diff_im  = trial_im - {1'b0, i_den};
        ge_re    = trial_re >= {1'b0, i_den};
        ge_im    = trial_im >= {1'b0, i_den};
        if (i_ctl.is_div) begin
            n_rem_re = ge_re ? diff_re[2*W-1:0] : trial_re[2*W-1:0];
            n_rem_im = ge_im ? diff_im[2*W-1:0] : trial_im[2*W-1:0];
            n_x_re   = {i_x_re[W-2:0], ge_re};
            n_x_im   = {i_x_im[W-2:0], ge_im};
        end else begin
            n_rem_re = i_rem_re;
            n_rem_im = i_rem_im;
            n_x_re   = i_x_re;
            n_x_im   = i_x_im;
        end
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den    <= i_den;
            o_rem_re <= n_rem_re;
            o_rem_im <= n_rem_im;
            o_x_re   <= n_x_re;
            o_x_im   <= n_x_im;
        end
    end

endmodule

// ----- design/complex_arithmetic_unit.sv -----
// Complex add, subtract, multiply and divide on signed fixed point operands
// (DATA_WIDTH bits, FRACTION_BITS fraction bits, taken from the low bits of
// each 32-bit port). The unit is fully pipelined: it takes one transfer per
// cycle while o_stall is low, and it returns results in order. The divider
// makes one quotient bit per pipeline stage; all operations use the same
// path.
// Multiply rounds toward minus infinity, divide truncates toward zero, and
// results out of range saturate with o_overflow set. A divide by zero
// returns zero with o_divide_by_zero set.
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [OUT_W-1:0] i_a_real,
    input  logic [OUT_W-1:0] i_a_imag,
    input  logic [OUT_W-1:0] i_b_real,
    input  logic [OUT_W-1:0] i_b_imag,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_result_real,
    output logic [OUT_W-1:0] o_result_imag,
    output logic             o_overflow,
    output logic             o_divide_by_zero
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int NW = 2*W + 1 + F;                       // shifted dividend
    localparam int HW = NW - W;                            // dividend high part
    localparam int CW = (HW > 2*W) ? HW : 2*W;             // compare width

    // Saturate a wide signed value to W bits; MSB of result is the flag
    function automatic logic [W:0] f_sat(input logic signed [2*W:0] v);
        logic fits;
        fits = (&v[2*W:W-1]) | ~(|v[2*W:W-1]);
        if (fits) begin
            f_sat = {1'b0, v[W-1:0]};
        end else if (v[2*W]) begin
            f_sat = {1'b1, 1'b1, {(W-1){1'b0}}};
        end else begin
            f_sat = {1'b1, 1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // Apply sign to a quotient magnitude with saturation
    function automatic logic [W:0] f_fin(input logic neg, input logic sat,
                                         input logic [W-1:0] q);
        logic [W-1:0] q_neg;
        q_neg = -q;
        if (!neg) begin
            if (sat || q[W-1]) begin
                f_fin = {1'b1, 1'b0, {(W-1){1'b1}}};
            end else begin
                f_fin = {1'b0, q};
            end
        end else begin
            if (sat || (q[W-1] && (|q[W-2:0]))) begin
                f_fin = {1'b1, 1'b1, {(W-1){1'b0}}};
            end else begin
                f_fin = {1'b0, q_neg};
            end
        end
    endfunction

    // Stage enables: a stage moves when empty or when its successor moves
    logic           en_1, en_2, en_3, en_o;
    logic           st_en [W+1];

    t_ctl           st_ctl    [W+1];
    logic [2*W-1:0] st_den    [W+1];
    logic [2*W-1:0] st_rem_re [W+1];
    logic [2*W-1:0] st_rem_im [W+1];
    logic [W-1:0]   st_x_re   [W+1];
    logic [W-1:0]   st_x_im   [W+1];

    // Stage 1: operand capture
    logic                  r1_valid;
    t_kind                 r1_kind;
    logic signed [W-1:0]   r1_ar, r1_ai, r1_br, r1_bi;

    // Stage 2: products and add/subtract
    logic                  r2_valid;
    t_kind                 r2_kind;
    logic signed [2*W-1:0] r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir, r2_p_bb, r2_p_jj;
    logic signed [W:0]     r2_as_re, r2_as_im;

    // Stage 3: sums of products
    logic                  r3_valid;
    t_kind                 r3_kind;
    logic signed [2*W:0]   r3_mre, r3_mim, r3_dre, r3_dim;
    logic [2*W-1:0]        r3_den;
    logic signed [W:0]     r3_as_re, r3_as_im;

    // Output stage
    logic                  r_o_valid;
    logic signed [W-1:0]   r_o_re, r_o_im;
    logic                  r_o_ovf, r_o_dbz;

    assign en_o    = !r_o_valid || !i_stall;
    assign en_3    = !r3_valid || st_en[0];
    assign en_2    = !r2_valid || en_3;
    assign en_1    = !r1_valid || en_2;
    assign o_stall = !en_1;

    for (genvar k = 0; k <= W; k++) begin : g_en
        if (k == W) begin : g_last
            assign st_en[k] = !st_ctl[k].valid || en_o;
        end else begin : g_mid
            assign st_en[k] = !st_ctl[k].valid || st_en[k+1];
        end
    end

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en_1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_1) begin
            r1_kind <= t_kind'(i_kind);
            r1_ar   <= i_a_real[W-1:0];
            r1_ai   <= i_a_imag[W-1:0];
            r1_br   <= i_b_real[W-1:0];
            r1_bi   <= i_b_imag[W-1:0];
        end
    end

    // Stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en_2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_2) begin
            r2_kind <= r1_kind;
            r2_p_rr <= r1_ar * r1_br;
            r2_p_ii <= r1_ai * r1_bi;
            r2_p_ri <= r1_ar * r1_bi;
            r2_p_ir <= r1_ai * r1_br;
            r2_p_bb <= r1_br * r1_br;
            r2_p_jj <= r1_bi * r1_bi;
            if (r1_kind == KIND_SUB) begin
                r2_as_re <= (W+1)'(r1_ar) - (W+1)'(r1_br);
                r2_as_im <= (W+1)'(r1_ai) - (W+1)'(r1_bi);
            end else begin
                r2_as_re <= (W+1)'(r1_ar) + (W+1)'(r1_br);
                r2_as_im <= (W+1)'(r1_ai) + (W+1)'(r1_bi);
            end
        end
    end

    // Stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en_3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_3) begin
            r3_kind  <= r2_kind;
            r3_mre   <= (2*W+1)'(r2_p_rr) - (2*W+1)'(r2_p_ii);
            r3_mim   <= (2*W+1)'(r2_p_ri) + (2*W+1)'(r2_p_ir);
            r3_dre   <= (2*W+1)'(r2_p_rr) + (2*W+1)'(r2_p_ii);
            r3_dim   <= (2*W+1)'(r2_p_ir) - (2*W+1)'(r2_p_ri);
            r3_den   <= $unsigned(r2_p_bb) + $unsigned(r2_p_jj);
            r3_as_re <= r2_as_re;
            r3_as_im <= r2_as_im;
        end
    end

    // Divider entry: non-divide results finish here, divides get set up
    logic signed [2*W:0] m_re, m_im;
    logic [W:0]          n_sat_re, n_sat_im;
    logic [2*W:0]        mag_re, mag_im;
    logic [NW-1:0]       num_re, num_im;
    logic [CW-1:0]       hi_re, hi_im, den_ext;
    logic                den_zero;
    t_ctl                n_ctl;
    logic [2*W-1:0]      n_rem_re, n_rem_im;
    logic [W-1:0]        n_x_re, n_x_im;

    always_comb begin
        if (r3_kind == KIND_MUL) begin
            m_re = r3_mre >>> F;
            m_im = r3_mim >>> F;
        end else begin
            m_re = (2*W+1)'(r3_as_re);
            m_im = (2*W+1)'(r3_as_im);
        end
        n_sat_re = f_sat(m_re);
        n_sat_im = f_sat(m_im);

        mag_re   = r3_dre[2*W] ? $unsigned(-r3_dre) : $unsigned(r3_dre);
        mag_im   = r3_dim[2*W] ? $unsigned(-r3_dim) : $unsigned(r3_dim);
        num_re   = NW'(mag_re) << F;
        num_im   = NW'(mag_im) << F;
        hi_re    = CW'(num_re[NW-1:W]);
        hi_im    = CW'(num_im[NW-1:W]);
        den_ext  = CW'(r3_den);
        den_zero = (r3_den == '0);

        n_ctl        = '0;
        n_ctl.valid  = r3_valid;
        n_rem_re     = '0;
        n_rem_im     = '0;
        if (r3_kind == KIND_DIV) begin
            n_ctl.dbz    = den_zero;
            n_ctl.is_div = !den_zero;
            n_ctl.sat_re = hi_re >= den_ext;
            n_ctl.sat_im = hi_im >= den_ext;
            n_ctl.neg_re = r3_dre[2*W];
            n_ctl.neg_im = r3_dim[2*W];
            if (den_zero) begin
                n_x_re = '0;
                n_x_im = '0;
            end else begin
                n_x_re   = num_re[W-1:0];
                n_x_im   = num_im[W-1:0];
                n_rem_re = hi_re[2*W-1:0];
                n_rem_im = hi_im[2*W-1:0];
            end
        end else begin
            n_ctl.ovf = n_sat_re[W] | n_sat_im[W];
            n_x_re    = n_sat_re[W-1:0];
            n_x_im    = n_sat_im[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            st_ctl[0] <= '0;
        end else if (st_en[0]) begin
            st_ctl[0] <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_en[0]) begin
            st_den[0]    <= r3_den;
            st_rem_re[0] <= n_rem_re;
            st_rem_im[0] <= n_rem_im;
            st_x_re[0]   <= n_x_re;
            st_x_im[0]   <= n_x_im;
        end
    end

    // Divider: one quotient bit per stage
    for (genvar k = 1; k <= W; k++) begin : g_div
        cau_div_step #(
            .W (W)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (st_en[k]),
            .i_ctl    (st_ctl[k-1]),
            .i_den    (st_den[k-1]),
            .i_rem_re (st_rem_re[k-1]),
            .i_rem_im (st_rem_im[k-1]),
            .i_x_re   (st_x_re[k-1]),
            .i_x_im   (st_x_im[k-1]),
            .o_ctl    (st_ctl[k]),
            .o_den    (st_den[k]),
            .o_rem_re (st_rem_re[k]),
            .o_rem_im (st_rem_im[k]),
            .o_x_re   (st_x_re[k]),
            .o_x_im   (st_x_im[k])
        );
    end

    // Output stage: sign and saturate quotients, pass other results through
    logic [W:0] fin_re, fin_im;

    always_comb begin
        if (st_ctl[W].is_div) begin
            fin_re = f_fin(st_ctl[W].neg_re, st_ctl[W].sat_re, st_x_re[W]);
            fin_im = f_fin(st_ctl[W].neg_im, st_ctl[W].sat_im, st_x_im[W]);
        end else begin
            fin_re = {st_ctl[W].ovf, st_x_re[W]};
            fin_im = {1'b0, st_x_im[W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= st_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_re  <= fin_re[W-1:0];
            r_o_im  <= fin_im[W-1:0];
            r_o_ovf <= fin_re[W] | fin_im[W];
            r_o_dbz <= st_ctl[W].dbz;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_result_real    = OUT_W'(r_o_re);
    assign o_result_imag    = OUT_W'(r_o_im);
    assign o_overflow       = r_o_ovf;
    assign o_divide_by_zero = r_o_dbz;

endmodule

// ----- design/cau_checker.sv -----
// Port-level checks for the complex arithmetic unit
module cau_checker import cau_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic [OUT_W-1:0] o_result_real,
    input logic [OUT_W-1:0] o_result_imag,
    input logic             o_overflow,
    input logic             o_divide_by_zero
);

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Zero divisor gives a zero result without saturation
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |->
            o_result_real == '0 && o_result_imag == '0 && !o_overflow)
        else $error("divide by zero with nonzero result or overflow");

    // The two flags never appear together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow && o_divide_by_zero))
        else $error("overflow and divide by zero both set");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_real)
            && $stable(o_result_imag) && $stable(o_overflow))
        else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// ----- tb/complex_arithmetic_unit_tb.sv -----
module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 37;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
        logic        dbz;
    } t_cplx_result;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_kind            in_kind = KIND_ADD;
    logic [OUT_W-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [OUT_W-1:0] res_re, res_im;
    logic             res_ovf, res_dbz;

    t_cplx_result expected_q[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  hold_off_cycles = 0;
    bit  random_out_stall = 1'b1;

    complex_arithmetic_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_kind(in_kind),
        .i_a_real(a_re), .i_a_imag(a_im), .i_b_real(b_re), .i_b_imag(b_im),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_result_real(res_re), .o_result_imag(res_im),
        .o_overflow(res_ovf), .o_divide_by_zero(res_dbz)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Saturate a wide signed value to 32 bits
    function automatic logic [31:0] saturate(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sh7FFF_FFFF) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sh8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Divide toward zero by a positive divisor
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] q;
        q = (n < 0) ? -((-n) / d) : n / d;
        return q;
    endfunction

    function automatic t_cplx_result complex_op(input t_kind k, input logic [31:0] ar_u,
                                                input logic [31:0] ai_u,
                                                input logic [31:0] br_u,
                                                input logic [31:0] bi_u);
        t_cplx_result r;
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        ar = $signed(ar_u);
        ai = $signed(ai_u);
        br = $signed(br_u);
        bi = $signed(bi_u);
        r = '0;
        case (k)
            KIND_ADD: begin
                r.re = saturate(ar + br, r.ovf);
                r.im = saturate(ai + bi, r.ovf);
            end
            KIND_SUB: begin
                r.re = saturate(ar - br, r.ovf);
                r.im = saturate(ai - bi, r.ovf);
            end
            KIND_MUL: begin
                re = (ar * br - ai * bi) >>> FRAC;
                im = (ar * bi + ai * br) >>> FRAC;
                r.re = saturate(re, r.ovf);
                r.im = saturate(im, r.ovf);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dbz = 1'b1;
                end else begin
                    re = (ar * br + ai * bi) <<< FRAC;
                    im = (ai * br - ar * bi) <<< FRAC;
                    r.re = saturate(div_trunc(re, den), r.ovf);
                    r.im = saturate(div_trunc(im, den), r.ovf);
                end
            end
        endcase
        return r;
    endfunction

    // Offer one operation after a random gap, wait for its transfer.
    // Valid stays high after the transfer so the next item can follow at once.
    task automatic send_op(input t_kind k, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi, input bit gaps = 1);
        int gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19)) : 0;
        if (gaps && $urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= k;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        expected_q.push_back(complex_op(k, ar, ai, br, bi));
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Output stall: random per result, or a long hold-off when requested
    initial begin
        int wait_n;
        forever begin
            @(posedge clk);
            if (hold_off_cycles > 0) begin
                out_stall <= 1'b1;
                hold_off_cycles--;
            end else if (random_out_stall && !out_stall && out_valid) begin
                wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
                if (wait_n > 0) begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge clk) begin
        t_cplx_result exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected re=%h im=%h", $time, res_re, res_im);
                error_count++;
            end else begin
                exp_r = expected_q.pop_front();
                if (res_re !== exp_r.re) begin
                    $display("%0t: real exp %h got %h", $time, exp_r.re, res_re);
                    error_count++;
                end
                if (res_im !== exp_r.im) begin
                    $display("%0t: imag exp %h got %h", $time, exp_r.im, res_im);
                    error_count++;
                end
                if (res_ovf !== exp_r.ovf) begin
                    $display("%0t: overflow exp %b got %b", $time, exp_r.ovf, res_ovf);
                    error_count++;
                end
                if (res_dbz !== exp_r.dbz) begin
                    $display("%0t: div by zero exp %b got %b", $time, exp_r.dbz, res_dbz);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stop offering and wait until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2 ** 20)) - (2 ** 19));
            3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
            4: return 32'h0;
            default: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6];
        ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                32'hFFFF_0000};
        send_op(KIND_ADD, ext[1], ext[2], ext[1], ext[2]);
        send_op(KIND_SUB, ext[1], ext[2], ext[2], ext[1]);
        send_op(KIND_SUB, ext[2], ext[1], ext[2], ext[1]);
        send_op(KIND_MUL, ext[1], ext[2], ext[1], ext[2]);
        send_op(KIND_MUL, ext[2], ext[2], ext[2], ext[2]);
        send_op(KIND_MUL, ext[3], ext[0], ext[4], ext[0]);
        send_op(KIND_MUL, 32'h0003_8000, 32'hFFFE_4000, 32'h0002_0000, 32'h0000_8000);
        send_op(KIND_DIV, ext[4], ext[4], ext[0], ext[0]);
        send_op(KIND_DIV, ext[0], ext[0], ext[0], ext[0]);
        send_op(KIND_DIV, ext[1], ext[2], ext[3], ext[0]);
        send_op(KIND_DIV, ext[2], ext[2], ext[2], ext[2]);
        send_op(KIND_DIV, ext[1], ext[1], ext[1], ext[1]);
        send_op(KIND_DIV, ext[3], ext[0], ext[0], ext[3]);
        send_op(KIND_DIV, ext[4], ext[5], ext[5], ext[4]);
        send_op(KIND_DIV, 32'h0007_0000, 32'h0, 32'h0002_0000, 32'h0);
        send_op(KIND_DIV, 32'hFFF9_0000, 32'h1, 32'h0002_0000, 32'h0);
        send_op(KIND_ADD, ext[0], ext[3], ext[3], ext[0]);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        repeat (n) send_op(t_kind'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                           rand_operand(), rand_operand());
    endtask

    // Long output hold-off while the input keeps streaming: the pipe fills up
    task automatic test_backpressure();
        hold_off_cycles = 200;
        repeat (150) send_op(t_kind'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                             rand_operand(), rand_operand(), 0);
        wait_drained();
    endtask

    // Back to back with no stalls on either side
    task automatic test_streaming();
        random_out_stall = 1'b0;
        repeat (150) send_op(t_kind'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                             rand_operand(), rand_operand(), 0);
        wait_drained();
        random_out_stall = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        wait_drained();
        test_backpressure();
        test_streaming();
        test_random(730);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/cau_pkg.sv
design/cau_div_step.sv
design/complex_arithmetic_unit.sv
design/cau_checker.sv
tb/complex_arithmetic_unit_tb.sv
